[hw/rtl/bffa_pkg.sv]
// Shared types and constants for the bitmap first-fit allocator.
`default_nettype none
package bffa_pkg;
    localparam int POOL_CAPACITY_DEF = 1024;
    localparam int WORD_BITS_DEF     = 32;
    localparam int FIELD_W           = 11;
    localparam int START_OUT_W       = 10;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_BAD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_RUN     = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_RANGE      = 2'd3
    } t_status;

    // classified command handed from front to back
    typedef struct packed {
        t_cmd               cmd;
        logic               reject;   // status already known, no bitmap work
        t_status            status;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] pool;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

[hw/rtl/bffa_front.sv]
// Front end: accepts commands, checks lengths and ranges, queues jobs.
`default_nettype none
module bffa_front (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire  [1:0]                    i_cmd,
    input  wire  [bffa_pkg::FIELD_W-1:0]  i_start,
    input  wire  [bffa_pkg::FIELD_W-1:0]  i_len,
    input  wire  [bffa_pkg::FIELD_W-1:0]  i_pool,
    output logic                          o_job_valid,
    input  wire                           i_job_ready,
    output bffa_pkg::t_job                o_job
);
    import bffa_pkg::*;

    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job n_job;
    logic [FIELD_W:0] w_end;
    logic w_push, w_pop;

    assign w_end = {1'b0, i_start} + {1'b0, i_len};

    always_comb begin
        n_job        = '0;
        n_job.cmd    = t_cmd'(i_cmd);
        n_job.start  = i_start;
        n_job.len    = i_len;
        n_job.pool   = i_pool;
        n_job.status = ST_OK;
        n_job.reject = 1'b0;
        case (t_cmd'(i_cmd))
            CMD_ALLOC: begin
                if (i_len == '0 || i_len > i_pool) begin
                    n_job.reject = 1'b1;
                    n_job.status = ST_BAD_LENGTH;
                end
            end
            CMD_FREE: begin
                if (i_len == '0) begin
                    n_job.reject = 1'b1;
                    n_job.status = ST_BAD_LENGTH;
                end else if (w_end > {1'b0, i_pool}) begin
                    n_job.reject = 1'b1;
                    n_job.status = ST_RANGE;
                end
            end
            CMD_QUERY: begin
                if (w_end > {1'b0, i_pool}) begin
                    n_job.reject = 1'b1;
                    n_job.status = ST_RANGE;
                end
            end
            default: begin
                n_job.reject = 1'b1;
                n_job.status = ST_RANGE;
            end
        endcase
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push = s_axis_tvalid && s_axis_tready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop = o_job_valid && i_job_ready;
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= n_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !s_axis_tready) else $error("accept when full");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_cnt != 2'd0)) else $error("pop from empty queue");
endmodule
`default_nettype wire

[hw/rtl/bffa_back.sv]
// Back end: bitmap memory, unit-by-word scan, marking, clearing, query.
`default_nettype none
module bffa_back #(
    parameter int POOL_CAPACITY = bffa_pkg::POOL_CAPACITY_DEF,
    parameter int WORD_BITS     = bffa_pkg::WORD_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_job_valid,
    output logic                            o_job_ready,
    input  bffa_pkg::t_job                  i_job,
    output logic                            o_res_valid,
    input  wire                             i_res_ready,
    output logic [1:0]                      o_status,
    output logic [bffa_pkg::START_OUT_W-1:0] o_granted,
    output logic                            o_free
);
    import bffa_pkg::*;

    localparam int WORDS = (POOL_CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int UW    = $clog2(POOL_CAPACITY + 1) + 1;

    // one bit per word: word was written since reset (else reads as zero)
    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORDS-1:0]     r_wvalid;
    logic [WORD_BITS-1:0] r_rdata;

    t_state r_st, n_st;
    t_job   r_job;
    logic [UW-1:0] r_u, n_u;       // current unit
    logic [UW-1:0] r_run, n_run;   // free units so far
    logic [UW-1:0] r_gs, n_gs;     // run start
    logic [UW-1:0] r_end;          // scan limit
    logic [UW-1:0] r_cnt, n_cnt;   // units left to mark or check
    logic          r_isfree, n_isfree;
    logic          r_found, n_found; // allocate run located, now marking
    logic [1:0]    r_status, n_status;
    logic          r_ovld;

    logic          w_rd_en, w_wr_en;
    logic [AW-1:0] w_addr;
    logic [WORD_BITS-1:0] w_wdata, w_word;
    logic [BW-1:0] w_bit;
    logic          w_taken, w_mark, w_set;

    assign w_addr = AW'(r_u >> BW);
    assign w_bit  = r_u[BW-1:0];
    assign w_word = r_rdata;
    assign w_taken = w_word[w_bit];

    // per-bit marking accumulates into the read register between writes
    always_ff @(posedge i_clk) begin
        if (w_rd_en) r_rdata <= r_wvalid[w_addr] ? r_mem[w_addr] : '0;
        else if (r_st == S_MARK && !w_mark && r_cnt != '0) r_rdata <= w_wdata;
        if (w_wr_en) r_mem[w_addr] <= w_wdata;
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_job_valid && !r_ovld)
                        n_st = i_job.reject ? S_DONE : S_RD;
            S_RD:   n_st = S_SCAN;
            S_SCAN: n_st = S_SCAN;
            S_MARK: n_st = S_MARK;
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_SCAN) begin
            if (r_job.cmd == CMD_ALLOC) begin
                if (r_u >= r_end) n_st = S_DONE;
                else if (!w_taken && r_run + 1'b1 == UW'(r_job.len)) n_st = S_RD;
                else if (r_u[BW-1:0] == '1) n_st = S_RD;
            end else if (r_job.cmd == CMD_QUERY) begin
                if (r_cnt == '0 || w_taken) n_st = S_DONE;
                else if (r_u[BW-1:0] == '1) n_st = S_RD;
            end else begin
                n_st = S_MARK;
            end
        end else if (r_st == S_RD && (r_job.cmd == CMD_FREE || r_found)) begin
            n_st = S_MARK;
        end
        if (r_st == S_MARK) begin
            if (r_cnt == '0) n_st = S_DONE;
            else if (w_mark && r_u[BW-1:0] == '1 && r_cnt != UW'(1)) n_st = S_RD;
            else if (w_mark && r_cnt == UW'(1)) n_st = S_DONE;
        end
    end

    // outputs and datapath
    assign w_set = (r_job.cmd == CMD_ALLOC);
    always_comb begin
        n_u = r_u; n_run = r_run; n_gs = r_gs; n_cnt = r_cnt;
        n_isfree = r_isfree; n_status = r_status; n_found = r_found;
        w_rd_en = 1'b0; w_wr_en = 1'b0; w_mark = 1'b0;
        w_wdata = w_word;
        case (r_st)
            S_IDLE: begin
                if (i_job_valid && !r_ovld) begin
                    n_u = (i_job.cmd == CMD_ALLOC) ? '0 : UW'(i_job.start);
                    n_run = '0;
                    n_gs = '0;
                    n_cnt = UW'(i_job.len);
                    n_isfree = 1'b0;
                    n_status = i_job.status;
                    n_found = 1'b0;
                end
            end
            S_RD: w_rd_en = 1'b1;
            S_SCAN: begin
                if (r_job.cmd == CMD_ALLOC) begin
                    if (r_u >= r_end) begin
                        n_status = ST_NO_RUN;
                        n_gs = '0;
                    end else if (w_taken) begin
                        n_run = '0;
                        n_u = r_u + 1'b1;
                    end else if (r_run + 1'b1 == UW'(r_job.len)) begin
                        n_gs = r_u + 1'b1 - UW'(r_job.len);
                        n_u = r_u + 1'b1 - UW'(r_job.len);
                        n_cnt = UW'(r_job.len);
                        n_found = 1'b1;
                    end else begin
                        n_run = r_run + 1'b1;
                        n_u = r_u + 1'b1;
                    end
                end else if (r_job.cmd == CMD_QUERY) begin
                    if (r_cnt == '0) n_isfree = 1'b1;
                    else if (w_taken) n_isfree = 1'b0;
                    else begin
                        n_u = r_u + 1'b1;
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            S_MARK: begin
                // set or clear bits up to the word end or the last unit, then write back
                if (r_cnt != '0) begin
                    w_wdata[w_bit] = w_set;
                    n_u = r_u + 1'b1;
                    n_cnt = r_cnt - 1'b1;
                    if (r_u[BW-1:0] == '1 || r_cnt == UW'(1)) begin
                        w_wr_en = 1'b1;
                        w_mark = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ovld <= 1'b0;
            r_wvalid <= '0;
        end else begin
            r_st <= n_st;
            if (w_wr_en) r_wvalid[w_addr] <= 1'b1;
            if (r_st == S_DONE) r_ovld <= 1'b1;
            else if (r_ovld && i_res_ready) r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u; r_run <= n_run; r_gs <= n_gs; r_cnt <= n_cnt;
        r_isfree <= n_isfree; r_status <= n_status; r_found <= n_found;
        if (r_st == S_IDLE && i_job_valid && !r_ovld) begin
            r_job <= i_job;
            r_end <= (UW'(i_job.pool) > UW'(POOL_CAPACITY)) ? UW'(POOL_CAPACITY)
                                                            : UW'(i_job.pool);
        end
        if (r_st == S_DONE) begin
            o_status <= r_status;
            o_granted <= (r_job.cmd == CMD_ALLOC && r_status == ST_OK)
                         ? START_OUT_W'(r_gs) : '0;
            o_free <= (r_job.cmd == CMD_QUERY && r_status == ST_OK) ? r_isfree : 1'b0;
        end
    end

    assign o_job_ready = (r_st == S_IDLE) && !r_ovld;
    assign o_res_valid = r_ovld;

    a_one_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_DONE) |-> !r_ovld) else $error("result overwritten");
    a_wr_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_st == S_MARK)) else $error("write outside mark");
    a_rd_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SCAN) |-> $past(r_st == S_RD || r_st == S_SCAN))
        else $error("scan without read");
endmodule
`default_nettype wire

[hw/rtl/bitmap_first_fit_allocator_top.sv]
// Top level of the bitmap first-fit allocator.
// Commands enter a two-deep queue after length and range checks; a back end then
// walks the bitmap one unit per cycle with a registered word read at each word
// boundary, and takes the next command only after its result transfer is done.
// An allocate scans the pool for the first free run of the requested length, then
// reads and marks that run word by word; a free clears its run word by word, and a
// query checks its range until a taken unit or the range end. A rejected command
// skips the bitmap and goes straight to its result.
// Bitmap reads as free after reset through per-word written flags, so no clearing
// pass is needed.
`default_nettype none
module bitmap_first_fit_allocator_top #(
    parameter int POOL_CAPACITY = bffa_pkg::POOL_CAPACITY_DEF,
    parameter int WORD_BITS     = bffa_pkg::WORD_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [10:0] i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,  // command[1:0], run_start[12:2], run_length[23:13]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata   // status[1:0], granted_start[11:2], run_is_free[12]
);
    import bffa_pkg::*;

    logic [FIELD_W-1:0] r_pool;
    logic w_jv, w_jr;
    t_job w_job;
    logic [1:0] w_st;
    logic [START_OUT_W-1:0] w_gs;
    logic w_fr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_pool <= (POOL_CAPACITY < 1024) ? FIELD_W'(POOL_CAPACITY) : FIELD_W'(1024);
        else if (i_cfg_we)
            r_pool <= (32'(i_cfg_wdata) > 32'(POOL_CAPACITY)) ? FIELD_W'(POOL_CAPACITY)
                                                               : i_cfg_wdata;
    end

    bffa_front u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
        .i_cmd(s_axis_tdata[1:0]), .i_start(s_axis_tdata[12:2]),
        .i_len(s_axis_tdata[23:13]), .i_pool(r_pool),
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    bffa_back #(.POOL_CAPACITY(POOL_CAPACITY), .WORD_BITS(WORD_BITS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_jv), .o_job_ready(w_jr), .i_job(w_job),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_status(w_st), .o_granted(w_gs), .o_free(w_fr)
    );

    assign m_axis_tdata = {3'b0, w_fr, w_gs, w_st};
endmodule
`default_nettype wire
